>>> hw/rtl/rv64icd_pkg.sv
// Shared widths, opcodes and control codes of the RV64 integer control decoder.
package rv64icd_pkg;

    // Field widths
    localparam int INSTR_W = 32;
    localparam int FLOW_W  = 8;
    localparam int REGS_W  = 3;
    localparam int SEL_W   = 2;
    localparam int IMM_W   = 3;
    localparam int FN_W    = 4;
    localparam int MEM_W   = 4;
    localparam int CSR_W   = 3;

    // Major opcodes
    localparam logic [6:0] OP_BRANCH   = 7'h63;
    localparam logic [6:0] OP_JAL      = 7'h6f;
    localparam logic [6:0] OP_JALR     = 7'h67;
    localparam logic [6:0] OP_LUI      = 7'h37;
    localparam logic [6:0] OP_AUIPC    = 7'h17;
    localparam logic [6:0] OP_LOAD     = 7'h03;
    localparam logic [6:0] OP_STORE    = 7'h23;
    localparam logic [6:0] OP_IMM      = 7'h13;
    localparam logic [6:0] OP_IMM_32   = 7'h1b;
    localparam logic [6:0] OP_REG      = 7'h33;
    localparam logic [6:0] OP_REG_32   = 7'h3b;
    localparam logic [6:0] OP_MISC_MEM = 7'h0f;
    localparam logic [6:0] OP_SYSTEM   = 7'h73;
    localparam logic [6:0] OP_AMO      = 7'h2f;
    localparam logic [6:0] OP_LOAD_FP  = 7'h07;
    localparam logic [6:0] OP_STORE_FP = 7'h27;
    localparam logic [6:0] OP_FMADD    = 7'h43;
    localparam logic [6:0] OP_FMSUB    = 7'h47;
    localparam logic [6:0] OP_FNMSUB   = 7'h4b;
    localparam logic [6:0] OP_FNMADD   = 7'h4f;
    localparam logic [6:0] OP_FP       = 7'h53;

    // funct7 values
    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [6:0] F7_SFENCE = 7'h09;

    // Shift-amount upper bits that mark an arithmetic right shift
    localparam logic [6:0] SHAMT_ARITH_64 = 7'h10;
    localparam logic [6:0] SHAMT_ARITH_32 = 7'h20;

    // System function codes (bits 31:20 of a privileged instruction)
    localparam logic [11:0] SYS_ECALL  = 12'h000;
    localparam logic [11:0] SYS_EBREAK = 12'h001;
    localparam logic [11:0] SYS_SRET   = 12'h102;
    localparam logic [11:0] SYS_MRET   = 12'h302;
    localparam logic [11:0] SYS_WFI    = 12'h105;
    localparam logic [11:0] SYS_MWFI   = 12'h305;
    localparam logic [11:0] SYS_DRET   = 12'h7b2;

    // Atomic function selects (bits 31:27)
    localparam logic [4:0] AMO_ADD  = 5'h00;
    localparam logic [4:0] AMO_SWAP = 5'h01;
    localparam logic [4:0] AMO_LR   = 5'h02;
    localparam logic [4:0] AMO_SC   = 5'h03;
    localparam logic [4:0] AMO_XOR  = 5'h04;
    localparam logic [4:0] AMO_OR   = 5'h08;
    localparam logic [4:0] AMO_AND  = 5'h0c;
    localparam logic [4:0] AMO_MIN  = 5'h10;
    localparam logic [4:0] AMO_MAX  = 5'h14;
    localparam logic [4:0] AMO_MINU = 5'h18;
    localparam logic [4:0] AMO_MAXU = 5'h1c;

    // funct3 values
    localparam logic [2:0] F3_ZERO = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SRL  = 3'd5;
    localparam logic [2:0] F3_W    = 3'd2;
    localparam logic [2:0] F3_D    = 3'd3;
    localparam logic [2:0] F3_LDMAX = 3'd7;
    localparam logic [2:0] F3_PRIV_RSV = 3'd4;

    // Flow flag bit positions
    localparam int FL_BRANCH = 0;
    localparam int FL_JAL    = 1;
    localparam int FL_JALR   = 2;
    localparam int FL_MEM    = 3;
    localparam int FL_AMO    = 4;
    localparam int FL_FENCE  = 5;
    localparam int FL_FENCEI = 6;
    localparam int FL_MULDIV = 7;

    // Register use bit positions
    localparam int RU_RS1 = 0;
    localparam int RU_RS2 = 1;
    localparam int RU_RD  = 2;

    typedef enum logic [SEL_W-1:0] {
        A1_ZERO = 2'd0,
        A1_RS1  = 2'd1,
        A1_PC   = 2'd2
    } alu1_sel_t;

    typedef enum logic [SEL_W-1:0] {
        A2_ZERO = 2'd0,
        A2_SIZE = 2'd1,
        A2_RS2  = 2'd2,
        A2_IMM  = 2'd3
    } alu2_sel_t;

    typedef enum logic [IMM_W-1:0] {
        IMM_I  = 3'd0,
        IMM_S  = 3'd1,
        IMM_SB = 3'd2,
        IMM_U  = 3'd3,
        IMM_UJ = 3'd4,
        IMM_Z  = 3'd5
    } imm_fmt_t;

    typedef enum logic [FN_W-1:0] {
        FN_ADD  = 4'd0,
        FN_SL   = 4'd1,
        FN_SEQ  = 4'd2,
        FN_SNE  = 4'd3,
        FN_XOR  = 4'd4,
        FN_SR   = 4'd5,
        FN_OR   = 4'd6,
        FN_AND  = 4'd7,
        FN_SUB  = 4'd10,
        FN_SRA  = 4'd11,
        FN_SLT  = 4'd12,
        FN_SGE  = 4'd13,
        FN_SLTU = 4'd14,
        FN_SGEU = 4'd15
    } alu_fn_t;

    typedef enum logic [MEM_W-1:0] {
        MC_NONE    = 4'd0,
        MC_READ    = 4'd1,
        MC_WRITE   = 4'd2,
        MC_SFENCE  = 4'd3,
        MC_LR      = 4'd4,
        MC_SC      = 4'd5,
        MC_AMOADD  = 4'd6,
        MC_AMOSWAP = 4'd7,
        MC_AMOXOR  = 4'd8,
        MC_AMOOR   = 4'd9,
        MC_AMOAND  = 4'd10,
        MC_AMOMIN  = 4'd11,
        MC_AMOMAX  = 4'd12,
        MC_AMOMINU = 4'd13,
        MC_AMOMAXU = 4'd14
    } mem_cmd_t;

    typedef enum logic [CSR_W-1:0] {
        CSR_NONE  = 3'd0,
        CSR_WRITE = 3'd1,
        CSR_SET   = 3'd2,
        CSR_CLEAR = 3'd3,
        CSR_SYS   = 3'd4
    } csr_cmd_t;

    // Decoded control bundle
    typedef struct packed {
        logic              legal;
        logic [FLOW_W-1:0] flow_flags;
        logic [REGS_W-1:0] reg_use;
        logic [SEL_W-1:0]  alu1_select;
        logic [SEL_W-1:0]  alu2_select;
        logic [IMM_W-1:0]  imm_format;
        logic              word_op;
        logic [FN_W-1:0]   alu_function;
        logic [MEM_W-1:0]  mem_command;
        logic [CSR_W-1:0]  csr_command;
        logic              fp_deferred;
    } ctrl_t;

endpackage

>>> hw/rtl/rv64icd_instr_if.sv
// Instruction request channel: valid/ready handshake with the raw instruction word.
interface rv64icd_instr_if
    import rv64icd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [INSTR_W-1:0] instruction;

    modport source (output valid, output instruction, input ready);
    modport sink   (input valid, input instruction, output ready);
endinterface

>>> hw/rtl/rv64icd_ctrl_if.sv
// Control bundle request channel: valid/ready handshake with the decoded fields.
interface rv64icd_ctrl_if
    import rv64icd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              legal;
    logic [FLOW_W-1:0] flow_flags;
    logic [REGS_W-1:0] reg_use;
    logic [SEL_W-1:0]  alu1_select;
    logic [SEL_W-1:0]  alu2_select;
    logic [IMM_W-1:0]  imm_format;
    logic              word_op;
    logic [FN_W-1:0]   alu_function;
    logic [MEM_W-1:0]  mem_command;
    logic [CSR_W-1:0]  csr_command;
    logic              fp_deferred;

    modport source (
        output valid, output legal, output flow_flags, output reg_use,
        output alu1_select, output alu2_select, output imm_format, output word_op,
        output alu_function, output mem_command, output csr_command, output fp_deferred,
        input ready
    );
    modport sink (
        input valid, input legal, input flow_flags, input reg_use,
        input alu1_select, input alu2_select, input imm_format, input word_op,
        input alu_function, input mem_command, input csr_command, input fp_deferred,
        output ready
    );
endinterface

>>> hw/rtl/rv64_integer_control_decoder_unit.sv
// Pipeline: an accepted request is held in the input register, decoded by combinational
// logic and stored in the result register, from which the sink takes it.
// Throughput: one request per cycle while the result register is empty or taken; the input
// register feeds a single pass of compare logic into the result register, and both advance.
// Stalls: ready back-propagates from the result register through the input register.
// Reset: rst_n clears both valid flags at once; the payload registers are not reset.
// Illegal words give an all-zero bundle; floating-point opcodes raise fp_deferred only.
module rv64_integer_control_decoder_unit
    import rv64icd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    rv64icd_instr_if.sink         instr,
    rv64icd_ctrl_if.source        ctrl
);

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [INSTR_W-1:0] in_word_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    ctrl_t              out_bundle_reg;
    ctrl_t              dec;

    logic               out_free;
    logic               in_fire;
    logic               in_advance;

    // Handshake: hold when the result register is full and not taken
    assign out_free   = !out_valid_reg || ctrl.ready;
    assign instr.ready = !in_valid_reg || out_free;
    assign in_fire    = instr.valid && instr.ready;
    assign in_advance = in_valid_reg && out_free;

    assign in_valid_next  = in_fire || (in_valid_reg && !out_free);
    assign out_valid_next = in_advance || (out_valid_reg && !ctrl.ready);

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_word_reg <= instr.instruction;
        end
        if (in_advance)
        begin
            out_bundle_reg <= dec;
        end
    end

    // Decode the registered word
    logic [6:0]  op;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [11:0] funct12;
    logic [4:0]  amo_sel;
    logic        is_imm;
    logic        is_word;
    logic [6:0]  shamt_hi;
    logic [6:0]  shamt_arith;
    logic        ok;
    alu_fn_t     arith_fn;
    alu_fn_t     cmp_fn;
    mem_cmd_t    amo_cmd;

    assign op      = in_word_reg[6:0];
    assign rd      = in_word_reg[11:7];
    assign f3      = in_word_reg[14:12];
    assign rs1     = in_word_reg[19:15];
    assign rs2     = in_word_reg[24:20];
    assign f7      = in_word_reg[31:25];
    assign funct12 = in_word_reg[31:20];
    assign amo_sel = in_word_reg[31:27];

    assign is_imm      = (op == OP_IMM) || (op == OP_IMM_32);
    assign is_word     = (op == OP_IMM_32) || (op == OP_REG_32);
    assign shamt_hi    = is_word ? f7 : {1'b0, f7[6:1]};
    assign shamt_arith = is_word ? SHAMT_ARITH_32 : SHAMT_ARITH_64;

    // Map funct3 to ALU codes
    always_comb
    begin
        case (f3)
            3'd0:    arith_fn = FN_ADD;
            3'd1:    arith_fn = FN_SL;
            3'd2:    arith_fn = FN_SLT;
            3'd3:    arith_fn = FN_SLTU;
            3'd4:    arith_fn = FN_XOR;
            3'd5:    arith_fn = FN_SR;
            3'd6:    arith_fn = FN_OR;
            default: arith_fn = FN_AND;
        endcase
        case (f3)
            3'd0:    cmp_fn = FN_SEQ;
            3'd1:    cmp_fn = FN_SNE;
            3'd4:    cmp_fn = FN_SLT;
            3'd5:    cmp_fn = FN_SGE;
            3'd6:    cmp_fn = FN_SLTU;
            3'd7:    cmp_fn = FN_SGEU;
            default: cmp_fn = FN_ADD;
        endcase
    end

    // Map the atomic select to a memory command
    always_comb
    begin
        case (amo_sel)
            AMO_ADD:  amo_cmd = MC_AMOADD;
            AMO_SWAP: amo_cmd = MC_AMOSWAP;
            AMO_LR:   amo_cmd = MC_LR;
            AMO_SC:   amo_cmd = MC_SC;
            AMO_XOR:  amo_cmd = MC_AMOXOR;
            AMO_OR:   amo_cmd = MC_AMOOR;
            AMO_AND:  amo_cmd = MC_AMOAND;
            AMO_MIN:  amo_cmd = MC_AMOMIN;
            AMO_MAX:  amo_cmd = MC_AMOMAX;
            AMO_MINU: amo_cmd = MC_AMOMINU;
            AMO_MAXU: amo_cmd = MC_AMOMAXU;
            default:  amo_cmd = MC_NONE;
        endcase
    end

    // Build the bundle; clear it for an illegal word
    always_comb
    begin
        dec = '0;
        ok  = 1'b0;
        case (op)
            OP_BRANCH:
            begin
                ok = (f3 != F3_W) && (f3 != F3_D);
                dec.flow_flags[FL_BRANCH] = 1'b1;
                dec.reg_use      = REGS_W'((1 << RU_RS1) | (1 << RU_RS2));
                dec.alu1_select  = A1_RS1;
                dec.alu2_select  = A2_RS2;
                dec.imm_format   = IMM_SB;
                dec.alu_function = cmp_fn;
            end
            OP_JAL:
            begin
                ok = 1'b1;
                dec.flow_flags[FL_JAL] = 1'b1;
                dec.reg_use[RU_RD] = 1'b1;
                dec.alu1_select = A1_PC;
                dec.alu2_select = A2_SIZE;
                dec.imm_format  = IMM_UJ;
            end
            OP_JALR:
            begin
                ok = (f3 == F3_ZERO);
                dec.flow_flags[FL_JALR] = 1'b1;
                dec.reg_use     = REGS_W'((1 << RU_RS1) | (1 << RU_RD));
                dec.alu1_select = A1_RS1;
                dec.alu2_select = A2_IMM;
            end
            OP_LUI, OP_AUIPC:
            begin
                ok = 1'b1;
                dec.reg_use[RU_RD] = 1'b1;
                dec.alu1_select = (op == OP_AUIPC) ? A1_PC : A1_ZERO;
                dec.alu2_select = A2_IMM;
                dec.imm_format  = IMM_U;
            end
            OP_LOAD:
            begin
                ok = (f3 != F3_LDMAX);
                dec.flow_flags[FL_MEM] = 1'b1;
                dec.reg_use     = REGS_W'((1 << RU_RS1) | (1 << RU_RD));
                dec.alu1_select = A1_RS1;
                dec.alu2_select = A2_IMM;
                dec.mem_command = MC_READ;
            end
            OP_STORE:
            begin
                ok = !f3[2];
                dec.flow_flags[FL_MEM] = 1'b1;
                dec.reg_use     = REGS_W'((1 << RU_RS1) | (1 << RU_RS2));
                dec.alu1_select = A1_RS1;
                dec.alu2_select = A2_IMM;
                dec.imm_format  = IMM_S;
                dec.mem_command = MC_WRITE;
            end
            OP_IMM, OP_IMM_32, OP_REG, OP_REG_32:
            begin
                dec.alu1_select = A1_RS1;
                dec.word_op     = is_word;
                dec.reg_use     = REGS_W'((1 << RU_RS1) | (1 << RU_RD));
                if (!is_imm && (f7 == F7_MULDIV))
                begin
                    // Multiply/divide: funct3 goes through as the function
                    ok = !(is_word && (f3 >= 3'd1) && (f3 <= 3'd3));
                    dec.flow_flags[FL_MULDIV] = 1'b1;
                    dec.reg_use[RU_RS2] = 1'b1;
                    dec.alu2_select  = A2_RS2;
                    dec.alu_function = {1'b0, f3};
                end
                else
                begin
                    ok = !(is_word && (f3 != F3_ZERO) && (f3 != F3_SLL) && (f3 != F3_SRL));
                    dec.alu_function = arith_fn;
                    if (is_imm)
                    begin
                        dec.alu2_select = A2_IMM;
                        if ((f3 == F3_SLL) || (f3 == F3_SRL))
                        begin
                            if ((shamt_hi != '0)
                                && !((f3 == F3_SRL) && (shamt_hi == shamt_arith)))
                            begin
                                ok = 1'b0;
                            end
                            if (shamt_hi == shamt_arith)
                            begin
                                dec.alu_function = FN_SRA;
                            end
                        end
                    end
                    else
                    begin
                        dec.alu2_select = A2_RS2;
                        dec.reg_use[RU_RS2] = 1'b1;
                        if ((f7 != F7_BASE)
                            && !((f7 == F7_ALT) && ((f3 == F3_ZERO) || (f3 == F3_SRL))))
                        begin
                            ok = 1'b0;
                        end
                        if (f7 == F7_ALT)
                        begin
                            dec.alu_function = (f3 == F3_ZERO) ? FN_SUB : FN_SRA;
                        end
                    end
                end
            end
            OP_MISC_MEM:
            begin
                ok = (f3 == F3_ZERO) || (f3 == F3_SLL);
                dec.flow_flags[FL_FENCE]  = 1'b1;
                dec.flow_flags[FL_FENCEI] = (f3 == F3_SLL);
            end
            OP_SYSTEM:
            begin
                if (f3 == F3_ZERO)
                begin
                    if (f7 == F7_SFENCE)
                    begin
                        // Address-translation fence goes to memory
                        ok = (rd == '0);
                        dec.flow_flags[FL_MEM] = 1'b1;
                        dec.reg_use     = REGS_W'((1 << RU_RS1) | (1 << RU_RS2));
                        dec.mem_command = MC_SFENCE;
                        dec.alu1_select = A1_RS1;
                    end
                    else
                    begin
                        ok = (rd == '0) && (rs1 == '0)
                            && ((funct12 == SYS_ECALL) || (funct12 == SYS_EBREAK)
                                || (funct12 == SYS_SRET) || (funct12 == SYS_MRET)
                                || (funct12 == SYS_WFI) || (funct12 == SYS_MWFI)
                                || (funct12 == SYS_DRET));
                        dec.csr_command = CSR_SYS;
                    end
                end
                else
                begin
                    // CSR access, register or immediate source
                    ok = (f3 != F3_PRIV_RSV);
                    dec.reg_use[RU_RD] = 1'b1;
                    case (f3[1:0])
                        2'd1:    dec.csr_command = CSR_WRITE;
                        2'd2:    dec.csr_command = CSR_SET;
                        default: dec.csr_command = CSR_CLEAR;
                    endcase
                    if (!f3[2])
                    begin
                        dec.reg_use[RU_RS1] = 1'b1;
                        dec.alu1_select = A1_RS1;
                    end
                    else
                    begin
                        dec.alu2_select = A2_IMM;
                        dec.imm_format  = IMM_Z;
                    end
                end
            end
            OP_AMO:
            begin
                ok = ((f3 == F3_W) || (f3 == F3_D)) && (amo_cmd != MC_NONE)
                    && !((amo_sel == AMO_LR) && (rs2 != '0));
                dec.flow_flags[FL_MEM] = 1'b1;
                dec.flow_flags[FL_AMO] = 1'b1;
                dec.mem_command = amo_cmd;
                dec.reg_use     = REGS_W'((1 << RU_RS1) | (1 << RU_RD));
                dec.reg_use[RU_RS2] = (amo_sel != AMO_LR);
                dec.alu1_select = A1_RS1;
            end
            OP_LOAD_FP, OP_STORE_FP, OP_FMADD, OP_FMSUB, OP_FNMSUB, OP_FNMADD, OP_FP:
            begin
                // Pass on to the floating-point decoder
                ok = 1'b1;
                dec.fp_deferred = 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        dec.legal = ok && !dec.fp_deferred;
        if (!ok)
        begin
            dec = '0;
        end
    end

    // Drive the result channel
    assign ctrl.valid        = out_valid_reg;
    assign ctrl.legal        = out_bundle_reg.legal;
    assign ctrl.flow_flags   = out_bundle_reg.flow_flags;
    assign ctrl.reg_use      = out_bundle_reg.reg_use;
    assign ctrl.alu1_select  = out_bundle_reg.alu1_select;
    assign ctrl.alu2_select  = out_bundle_reg.alu2_select;
    assign ctrl.imm_format   = out_bundle_reg.imm_format;
    assign ctrl.word_op      = out_bundle_reg.word_op;
    assign ctrl.alu_function = out_bundle_reg.alu_function;
    assign ctrl.mem_command  = out_bundle_reg.mem_command;
    assign ctrl.csr_command  = out_bundle_reg.csr_command;
    assign ctrl.fp_deferred  = out_bundle_reg.fp_deferred;

endmodule
